// ----- sv/srd_pkg.sv -----
package srd_pkg;

   localparam int unsigned MaxSamplesDefault     = 4096;
   localparam int unsigned MinNormSamplesDefault = 256;
   localparam int unsigned QueueDepth            = 2;

   localparam int unsigned SampleW   = 13;
   localparam int unsigned WordW     = 16;
   localparam int unsigned BinExpW   = 3;
   localparam int unsigned DecExpW   = 5;
   localparam int unsigned NormLimit = 4096;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_VERT     = 3'd1,
      ST_HORIZ    = 3'd2,
      ST_SHORT    = 3'd3,
      ST_NOT_NORM = 3'd4,
      ST_LONG     = 3'd5
   } status_type;

   typedef struct packed {
      logic signed [SampleW-1:0] sample_value;
      logic                      record_end;
      status_type                record_status;
      logic                      decode_en;
      logic [WordW-1:0]          horiz_word;
   } entry_type;

endpackage

// ----- sv/srd_req_if.sv -----
interface srd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] low_byte;
   logic [7:0] high_byte;
   logic       last_sample;

   modport source (output valid, low_byte, high_byte, last_sample, input ready);
   modport sink   (input valid, low_byte, high_byte, last_sample, output ready);
endinterface

// ----- sv/srd_rsp_if.sv -----
interface srd_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [srd_pkg::SampleW-1:0]      sample_value;
   logic                                    record_end;
   logic [2:0]                              record_status;
   logic signed [srd_pkg::BinExpW-1:0]      binary_exponent;
   logic signed [srd_pkg::DecExpW-1:0]      decimal_exponent;

   modport source (output valid, sample_value, record_end, record_status, binary_exponent,
                   decimal_exponent, input ready);
   modport sink   (input valid, sample_value, record_end, record_status, binary_exponent,
                   decimal_exponent, output ready);
endinterface

// ----- sv/srd_front.sv -----
module srd_front #(
   parameter int unsigned MAX_SAMPLES      = srd_pkg::MaxSamplesDefault,
   parameter int unsigned MIN_NORM_SAMPLES = srd_pkg::MinNormSamplesDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data,
   srd_req_if.sink             req,
   input  logic                q_full,
   output logic                q_push,
   output srd_pkg::entry_type  q_entry
);

   localparam int unsigned CntMax = (MAX_SAMPLES + 1 > MIN_NORM_SAMPLES) ?
                                    MAX_SAMPLES + 1 : MIN_NORM_SAMPLES;
   localparam int unsigned CntW   = $clog2(CntMax + 1);
   localparam int unsigned W      = srd_pkg::WordW;

   logic            norm_en_ff;
   logic [CntW-1:0] count_ff, count_in, next_count;
   logic [W-1:0]    hwa_ff, hwb_ff, vwa_ff, vwb_ff;
   logic [W-1:0]    hwa_in, hwb_in, vwa_in, vwb_in;
   logic [7:0]      lo, hi;
   logic [11:0]     raw;
   logic            collect;
   logic [3:0]      pos;
   srd_pkg::status_type status;

   assign req.ready = !q_full;
   assign q_push    = req.valid && !q_full;

   assign lo  = ~req.low_byte;
   assign hi  = ~req.high_byte;
   assign raw = {hi[3:0], lo};
   assign pos = count_ff[6:3];

   assign collect = norm_en_ff && (count_ff[CntW-1:8] == '0);

   always_comb begin
      hwa_in = hwa_ff;
      hwb_in = hwb_ff;
      vwa_in = vwa_ff;
      vwb_in = vwb_ff;
      if (collect) begin
         case ({count_ff[7], count_ff[2:0]})
            4'b0000: hwa_in[pos] = hi[4];
            4'b0001: hwb_in[pos] = hi[4];
            4'b1000: vwa_in[pos] = hi[4];
            4'b1001: vwb_in[pos] = hi[4];
            default: ;
         endcase
      end
   end

   assign next_count = (count_ff == CntW'(MAX_SAMPLES + 1)) ? count_ff : count_ff + 1'b1;

   always_comb begin
      status = srd_pkg::ST_OK;
      if (next_count > CntW'(MAX_SAMPLES)) begin
         status = srd_pkg::ST_LONG;
      end else if (norm_en_ff) begin
         if (next_count < CntW'(MIN_NORM_SAMPLES)) begin
            status = srd_pkg::ST_SHORT;
         end else if (vwa_in != vwb_in) begin
            status = srd_pkg::ST_VERT;
         end else if (hwa_in != hwb_in) begin
            status = srd_pkg::ST_HORIZ;
         end else if (hwa_in > W'(srd_pkg::NormLimit)) begin
            status = srd_pkg::ST_NOT_NORM;
         end
      end
   end

   always_comb begin
      q_entry.sample_value  = (raw > 12'd2048) ? {1'b1, raw} : {1'b0, raw};
      q_entry.record_end    = req.last_sample;
      q_entry.record_status = req.last_sample ? status : srd_pkg::ST_OK;
      q_entry.decode_en     = req.last_sample && norm_en_ff && (status == srd_pkg::ST_OK);
      q_entry.horiz_word    = hwa_in;
   end

   assign count_in = req.last_sample ? '0 : next_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         norm_en_ff <= 1'b0;
         count_ff   <= '0;
         hwa_ff     <= '0;
         hwb_ff     <= '0;
         vwa_ff     <= '0;
         vwb_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            norm_en_ff <= csr_wr_data;
         end
         if (q_push) begin
            count_ff <= count_in;
            if (req.last_sample) begin
               hwa_ff <= '0;
               hwb_ff <= '0;
               vwa_ff <= '0;
               vwb_ff <= '0;
            end else begin
               hwa_ff <= hwa_in;
               hwb_ff <= hwb_in;
               vwa_ff <= vwa_in;
               vwb_ff <= vwb_in;
            end
         end
      end
   end

endmodule

// ----- sv/srd_queue.sv -----
module srd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  srd_pkg::entry_type  push_entry,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output srd_pkg::entry_type  head
);

   localparam int unsigned Depth = srd_pkg::QueueDepth;
   localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW  = $clog2(Depth + 1);

   srd_pkg::entry_type mem_ff [Depth];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]    count_ff, count_in;

   assign full  = (count_ff == CntW'(Depth));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- sv/srd_back.sv -----
module srd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  srd_pkg::entry_type  q_head,
   output logic                q_pop,
   srd_rsp_if.source           rsp
);

   logic                                  valid_ff;
   logic signed [srd_pkg::SampleW-1:0]    sample_ff;
   logic                                  end_ff;
   srd_pkg::status_type                   status_ff;
   logic signed [srd_pkg::BinExpW-1:0]    bexp_ff, bexp_in;
   logic signed [srd_pkg::DecExpW-1:0]    dexp_ff, dexp_in;
   logic [srd_pkg::WordW-1:0]             h;
   logic [srd_pkg::DecExpW-1:0]           tens;

   assign q_pop = !q_empty && (!valid_ff || rsp.ready);
   assign h     = q_head.horiz_word;
   assign tens  = {3'b000, h[5:4]} + {2'b00, h[5:4], 1'b0};

   always_comb begin
      bexp_in = '0;
      dexp_in = '0;
      if (q_head.decode_en) begin
         bexp_in = $signed({1'b0, h[9:8]} - {1'b0, h[7:6]});
         dexp_in = $signed({3'b000, h[3:2]} + {3'b000, h[1:0]} - tens);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (q_pop) begin
         valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         sample_ff <= q_head.sample_value;
         end_ff    <= q_head.record_end;
         status_ff <= q_head.record_status;
         bexp_ff   <= bexp_in;
         dexp_ff   <= dexp_in;
      end
   end

   assign rsp.valid            = valid_ff;
   assign rsp.sample_value     = sample_ff;
   assign rsp.record_end       = end_ff;
   assign rsp.record_status    = status_ff;
   assign rsp.binary_exponent  = bexp_ff;
   assign rsp.decimal_exponent = dexp_ff;

endmodule

// ----- sv/scope_record_decoder_unit.sv -----
// Channel   Direction  Beat contents
// req_bus   in         low_byte, high_byte, last_sample
// rsp_bus   out        sample_value, record_end, record_status, binary/decimal exponent
// csr       in         norm_enable write (csr_wr_en, csr_wr_data)
//
// One beat is taken per cycle while the queue is not full; its result passes through the
// queue and the output register. The front decodes the sample and runs the record checks
// in the accept cycle, a two-entry queue feeds the back, which decodes the timebase into
// the output register. A stalled output fills the queue, and req_bus.ready drops only
// when the queue is full. Synchronous reset clears the record state, the queue and the output valid flag.
module scope_record_decoder_unit #(
   parameter int unsigned MAX_SAMPLES      = srd_pkg::MaxSamplesDefault,
   parameter int unsigned MIN_NORM_SAMPLES = srd_pkg::MinNormSamplesDefault
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      csr_wr_en,
   input  logic      csr_wr_data,
   srd_req_if.sink   req_bus,
   srd_rsp_if.source rsp_bus
);

   logic               q_full, q_push, q_pop, q_empty;
   srd_pkg::entry_type q_entry, q_head;

   srd_front #(
      .MAX_SAMPLES      (MAX_SAMPLES),
      .MIN_NORM_SAMPLES (MIN_NORM_SAMPLES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req_bus),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_entry     (q_entry)
   );

   srd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .head       (q_head)
   );

   srd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rsp     (rsp_bus)
   );

endmodule
